[hw/rtl/lrog_pkg.sv]
// Shared types, constants and helpers for the line raster occupancy grid block.
package lrog_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int GRID_COLS_DEF  = 256;
  localparam int GRID_ROWS_DEF  = 256;
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int PROBE_W    = 8;
  localparam int COUNT_W    = 13;

  // Register reset values
  localparam int GRID_W_RESET = 224;
  localparam int GRID_H_RESET = 192;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic calc_abs;
    logic init_walk;
    logic plot_step;
    logic clear_step;
    logic read_issue;
  } lrog_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic walk_last;
    logic clear_last;
  } lrog_sts_t;

  function automatic int lrog_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int lrog_min(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

endpackage

[hw/rtl/lrog_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lrog_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lrog_ctrl.sv]
// Controller state machine: clear sweep, draw walk sequencing and cell reads.
module lrog_ctrl import lrog_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      op_i,
  input  lrog_sts_t sts_i,
  output lrog_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ABS,
    ST_INIT,
    ST_PLOT,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = (op_i == OP_READ) ? ST_READ : ST_ABS;
      end
      ST_ABS:  state_d = ST_INIT;
      ST_INIT: state_d = ST_PLOT;
      ST_PLOT: begin
        if (sts_i.walk_last) state_d = ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && start_i;
    cmd_o.calc_abs   = (state_q == ST_ABS);
    cmd_o.init_walk  = (state_q == ST_INIT);
    cmd_o.plot_step  = (state_q == ST_PLOT);
    cmd_o.clear_step = (state_q == ST_CLEAR);
    cmd_o.read_issue = (state_q == ST_READ);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // A result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A read item goes through the read state to the result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == OP_READ)) |-> ##2 done_o)
    else $error("read result not on time");

  // The last plot of a walk is followed by the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.plot_step && sts_i.walk_last) |=> done_o)
    else $error("draw result missing after last plot");

  // Result strobe only while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result strobe while idle");

endmodule

[hw/rtl/lrog_dp.sv]
// Datapath: configuration registers, Bresenham walk, plot counter and grid memory.
module lrog_dp import lrog_pkg::*; #(
  parameter int GRID_COLS_MAX = GRID_COLS_DEF,
  parameter int GRID_ROWS_MAX = GRID_ROWS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrog_cmd_t                    cmd_i,
  output lrog_sts_t                    sts_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [PROBE_W-1:0]           probe_x_i,
  input  logic [PROBE_W-1:0]           probe_y_i,
  output logic                         cell_occupied_o,
  output logic [COUNT_W-1:0]           pixels_marked_o
);

  localparam int COL_AW = $clog2(GRID_COLS_MAX);
  localparam int ROW_AW = $clog2(GRID_ROWS_MAX);
  localparam int ADDR_W = COL_AW + ROW_AW;
  localparam int DEPTH  = 2 ** ADDR_W;
  // Position width: holds walk coordinates and the effective bounds
  localparam int PW     = lrog_max(lrog_max(COORD_BITS + 2, CFG_DATA_W + 1),
                                   lrog_max(COL_AW + 2, ROW_AW + 2));
  localparam int MAG_W  = COORD_BITS;
  localparam int ERR_W  = COORD_BITS + 3;
  localparam int EFF_W_RST = lrog_min(GRID_W_RESET, GRID_COLS_MAX);
  localparam int EFF_H_RST = lrog_min(GRID_H_RESET, GRID_ROWS_MAX);
  localparam logic [PW-1:0] COLS_P = PW'(GRID_COLS_MAX);
  localparam logic [PW-1:0] ROWS_P = PW'(GRID_ROWS_MAX);

  // Effective bounds, clamped at write time
  logic [PW-1:0] eff_w_q, eff_h_q;
  logic [PW-1:0] cfg_ext;

  assign cfg_ext = PW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= PW'(EFF_W_RST);
      eff_h_q <= PW'(EFF_H_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  eff_w_q <= (cfg_ext > COLS_P) ? COLS_P : cfg_ext;
        CFG_IDX_HEIGHT: eff_h_q <= (cfg_ext > ROWS_P) ? ROWS_P : cfg_ext;
        default: ;
      endcase
    end
  end

  // Item registers
  logic                 op_q;
  logic [PW-1:0]        sx_q, sy_q, ex_q, ey_q, dx_q, dy_q;
  logic [PROBE_W-1:0]   probe_x_q, probe_y_q;
  logic                 probe_ok_q;
  logic [PW-1:0]        sx_d, sy_d, ex_d, ey_d;
  logic [PW-1:0]        probe_x_ext, probe_y_ext;

  assign sx_d = PW'(start_x_i);
  assign sy_d = PW'(start_y_i);
  assign ex_d = PW'(end_x_i);
  assign ey_d = PW'(end_y_i);
  assign probe_x_ext = PW'(probe_x_i);
  assign probe_y_ext = PW'(probe_y_i);

  // Setup registers
  logic [MAG_W-1:0] adx_q, ady_q;
  logic             dx_neg_q, dy_neg_q, step_pos_q;
  logic [PW-1:0]    adx_full, ady_full;
  logic             dx_pos, dy_pos;

  assign adx_full = dx_q[PW-1] ? (~dx_q + PW'(1)) : dx_q;
  assign ady_full = dy_q[PW-1] ? (~dy_q + PW'(1)) : dy_q;
  assign dx_pos   = !dx_q[PW-1] && (|dx_q);
  assign dy_pos   = !dy_q[PW-1] && (|dy_q);

  // Walk registers
  logic                    xmaj_q;
  logic [PW-1:0]           x_q, y_q;
  logic signed [ERR_W-1:0] err_q, inc_a_q, inc_b_q;
  logic [MAG_W-1:0]        rem_q;
  logic [COUNT_W-1:0]      count_q;

  // Initial walk values
  logic                    xmaj;
  logic [MAG_W-1:0]        maj, mnr;
  logic signed [ERR_W-1:0] maj_e, mnr_e;
  logic                    backward;

  assign xmaj     = (ady_q <= adx_q);
  assign maj      = xmaj ? adx_q : ady_q;
  assign mnr      = xmaj ? ady_q : adx_q;
  assign maj_e    = signed'(ERR_W'(maj));
  assign mnr_e    = signed'(ERR_W'(mnr));
  assign backward = xmaj ? dx_neg_q : dy_neg_q;

  // Walk step
  logic          take_a;
  logic [PW-1:0] step_v;
  logic          in_b;

  assign take_a = xmaj_q ? err_q[ERR_W-1] : (err_q[ERR_W-1] || (err_q == '0));
  assign step_v = step_pos_q ? PW'(1) : '1;
  assign in_b   = !x_q[PW-1] && (x_q < eff_w_q) && !y_q[PW-1] && (y_q < eff_h_q);

  // Capture item, then set up and run the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_i;
      sx_q       <= sx_d;
      sy_q       <= sy_d;
      ex_q       <= ex_d;
      ey_q       <= ey_d;
      dx_q       <= ex_d - sx_d;
      dy_q       <= ey_d - sy_d;
      probe_x_q  <= probe_x_i;
      probe_y_q  <= probe_y_i;
      probe_ok_q <= (probe_x_ext < eff_w_q) && (probe_y_ext < eff_h_q);
    end
    if (cmd_i.calc_abs) begin
      adx_q      <= adx_full[MAG_W-1:0];
      ady_q      <= ady_full[MAG_W-1:0];
      dx_neg_q   <= dx_q[PW-1];
      dy_neg_q   <= dy_q[PW-1];
      step_pos_q <= (dx_q[PW-1] && dy_q[PW-1]) || (dx_pos && dy_pos);
    end
    if (cmd_i.init_walk) begin
      xmaj_q  <= xmaj;
      err_q   <= (mnr_e <<< 1) - maj_e;
      inc_a_q <= mnr_e <<< 1;
      inc_b_q <= (mnr_e - maj_e) <<< 1;
      x_q     <= backward ? ex_q : sx_q;
      y_q     <= backward ? ey_q : sy_q;
      rem_q   <= maj;
      count_q <= '0;
    end
    if (cmd_i.plot_step) begin
      count_q <= count_q + COUNT_W'(in_b);
      if (rem_q != '0) begin
        rem_q <= rem_q - MAG_W'(1);
        if (take_a) begin
          err_q <= err_q + inc_a_q;
        end else begin
          err_q <= err_q + inc_b_q;
        end
        if (xmaj_q) begin
          x_q <= x_q + PW'(1);
          if (!take_a) y_q <= y_q + step_v;
        end else begin
          y_q <= y_q + PW'(1);
          if (!take_a) x_q <= x_q + step_v;
        end
      end
    end
  end

  // Clear sweep address
  logic [ADDR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  assign sts_o.clear_last = &clr_cnt_q;
  assign sts_o.walk_last  = (rem_q == '0);

  // Grid memory ports
  logic              ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0]     px_ext, py_ext;

  assign px_ext    = PW'(probe_x_q);
  assign py_ext    = PW'(probe_y_q);
  assign ram_we    = cmd_i.clear_step || (cmd_i.plot_step && in_b);
  assign ram_wdata = !cmd_i.clear_step;
  assign ram_waddr = cmd_i.clear_step ? clr_cnt_q
                                      : {y_q[ROW_AW-1:0], x_q[COL_AW-1:0]};
  assign ram_raddr = {py_ext[ROW_AW-1:0], px_ext[COL_AW-1:0]};

  lrog_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read_issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result fields
  assign cell_occupied_o = (op_q == OP_READ) && ram_rdata && probe_ok_q;
  assign pixels_marked_o = (op_q == OP_DRAW) ? count_q : '0;

endmodule

[hw/rtl/line_raster_to_occupancy_grid_top.sv]
// Top level of the line raster occupancy grid: controller, datapath and grid RAM.
// Draw item: after acceptance the walk is set up in the abs and init states, then the plot
//   state steps one cell a cycle, in-bounds ones through the single grid RAM write port.
// Read item: the read state issues a registered RAM read, and the result strobe follows it.
// A new item is accepted the cycle after the strobe; the receiver cannot stall.
// After reset the grid is swept to zero, one cell a cycle over all 2^(log2 cols + log2 rows)
//   cells (65536 at default size) with busy high; config writes are taken meanwhile.
module line_raster_to_occupancy_grid_top import lrog_pkg::*; #(
  parameter int GRID_COLS_MAX = GRID_COLS_DEF,
  parameter int GRID_ROWS_MAX = GRID_ROWS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  output logic                         done_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         op_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [PROBE_W-1:0]           probe_x_i,
  input  logic [PROBE_W-1:0]           probe_y_i,
  output logic                         cell_occupied_o,
  output logic [COUNT_W-1:0]           pixels_marked_o
);

  lrog_cmd_t cmd;
  lrog_sts_t sts;

  lrog_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  lrog_dp #(
    .GRID_COLS_MAX (GRID_COLS_MAX),
    .GRID_ROWS_MAX (GRID_ROWS_MAX),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .probe_x_i       (probe_x_i),
    .probe_y_i       (probe_y_i),
    .cell_occupied_o (cell_occupied_o),
    .pixels_marked_o (pixels_marked_o)
  );

endmodule

[verif/tb_line_raster_to_occupancy_grid_top.sv]
// Testbench for the line raster occupancy grid: random and directed items, checked by a scoreboard.
module tb_line_raster_to_occupancy_grid_top import lrog_pkg::*;;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int GRID_CELLS  = GRID_COLS_DEF * GRID_ROWS_DEF;
  // the clearing pass after reset dominates the longest quiet stretch
  localparam int STALL_LIMIT = 200000;
  localparam int PHASE_ITEMS = 275;
  localparam int PHASES      = 6;

  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef struct packed {
    logic               occ;
    logic [COUNT_W-1:0] count;
  } cell_count_t;

  // Grid image, register copies and expected results in arrival order
  class raster_scoreboard;
    bit          occupied [GRID_CELLS];
    int          cols_cfg;
    int          rows_cfg;
    cell_count_t pending_cell_counts[$];
    int          errors;

    function new();
      cols_cfg = GRID_W_RESET;
      rows_cfg = GRID_H_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_WIDTH) begin
        cols_cfg = int'(data);
      end else if (idx == CFG_IDX_HEIGHT) begin
        rows_cfg = int'(data);
      end
    endfunction

    // Cap a register at the physical grid size
    function int dim_in_use(int cfg, int cap);
      return (cfg > cap) ? cap : cfg;
    endfunction

    function int mark_cell(int x, int y);
      if (x < 0 || y < 0) return 0;
      if (x >= dim_in_use(cols_cfg, GRID_COLS_DEF) || y >= dim_in_use(rows_cfg, GRID_ROWS_DEF))
        return 0;
      occupied[y * GRID_COLS_DEF + x] = 1'b1;
      return 1;
    endfunction

    // Walk the segment along its major axis and mark every in-bounds cell
    function int trace_line(int x1, int y1, int x2, int y2);
      int dx, dy, adx, ady, dir, x, y, stop, err, hits;
      dx   = x2 - x1;
      dy   = y2 - y1;
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      dir  = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
      hits = 0;
      if (ady <= adx) begin
        err = 2 * ady - adx;
        if (dx >= 0) begin
          x = x1; y = y1; stop = x2;
        end else begin
          x = x2; y = y2; stop = x1;
        end
        hits += mark_cell(x, y);
        while (x < stop) begin
          x++;
          if (err < 0) begin
            err += 2 * ady;
          end else begin
            y   += dir;
            err += 2 * (ady - adx);
          end
          hits += mark_cell(x, y);
        end
      end else begin
        err = 2 * adx - ady;
        if (dy >= 0) begin
          x = x1; y = y1; stop = y2;
        end else begin
          x = x2; y = y2; stop = y1;
        end
        hits += mark_cell(x, y);
        while (y < stop) begin
          y++;
          if (err <= 0) begin
            err += 2 * adx;
          end else begin
            x   += dir;
            err += 2 * (adx - ady);
          end
          hits += mark_cell(x, y);
        end
      end
      return hits;
    endfunction

    // Apply an accepted item to the grid image and queue its result
    function void note_item(logic op, logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                            logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey,
                            logic [PROBE_W-1:0] px, logic [PROBE_W-1:0] py);
      cell_count_t res;
      int          hits;
      res = '0;
      if (op == OP_DRAW) begin
        hits      = trace_line(int'(sx), int'(sy), int'(ex), int'(ey));
        res.count = hits[COUNT_W-1:0];
      end else if (int'(px) < dim_in_use(cols_cfg, GRID_COLS_DEF) &&
                   int'(py) < dim_in_use(rows_cfg, GRID_ROWS_DEF)) begin
        res.occ = occupied[int'(py) * GRID_COLS_DEF + int'(px)];
      end
      pending_cell_counts = {pending_cell_counts, res};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic occ, logic [COUNT_W-1:0] count);
      cell_count_t want;
      if (pending_cell_counts.size() == 0) begin
        report($sformatf("result cell=%0b count=%0d with no item pending", occ, count));
      end else begin
        want = pending_cell_counts.pop_front();
        if (occ !== want.occ)
          report($sformatf("cell_occupied got %0b want %0b", occ, want.occ));
        if (count !== want.count)
          report($sformatf("pixels_marked got %0d want %0d", count, want.count));
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni     = 1'b0;
  logic                         start      = 1'b0;
  logic                         busy;
  logic                         done_o;
  logic                         cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i = '0;
  logic                         op_i       = OP_DRAW;
  logic signed [COORD_W-1:0]    start_x_i  = '0;
  logic signed [COORD_W-1:0]    start_y_i  = '0;
  logic signed [COORD_W-1:0]    end_x_i    = '0;
  logic signed [COORD_W-1:0]    end_y_i    = '0;
  logic [PROBE_W-1:0]           probe_x_i  = '0;
  logic [PROBE_W-1:0]           probe_y_i  = '0;
  logic                         cell_occupied_o;
  logic [COUNT_W-1:0]           pixels_marked_o;

  raster_scoreboard sb = new();
  int               quiet_cycles = 0;

  line_raster_to_occupancy_grid_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .done_o          (done_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .probe_x_i       (probe_x_i),
    .probe_y_i       (probe_y_i),
    .cell_occupied_o (cell_occupied_o),
    .pixels_marked_o (pixels_marked_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every strobed result
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && done_o) sb.check_result(cell_occupied_o, pixels_marked_o);
    end
  end

  // End the run when neither side moves an item for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Present one item and hold it until the block takes it
  task automatic issue(logic op, int sx, int sy, int ex, int ey, int px, int py);
    op_i      <= op;
    start_x_i <= sx[COORD_W-1:0];
    start_y_i <= sy[COORD_W-1:0];
    end_x_i   <= ex[COORD_W-1:0];
    end_y_i   <= ey[COORD_W-1:0];
    probe_x_i <= px[PROBE_W-1:0];
    probe_y_i <= py[PROBE_W-1:0];
    start     <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(op_i, start_x_i, start_y_i, end_x_i, end_y_i, probe_x_i, probe_y_i);
  endtask

  task automatic draw(int sx, int sy, int ex, int ey);
    issue(OP_DRAW, sx, sy, ex, ey, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic probe(int px, int py);
    issue(OP_READ, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
          $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, px, py);
  endtask

  // Drop start, then wait until every result is in and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_cell_counts.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the enable after the last write
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_grid(int cols, int rows, bit poke_spare);
    if (poke_spare) begin
      write_cfg(CFG_IDX_SPARE_LO, CFG_DATA_W'($urandom_range(0, 511)));
      write_cfg(CFG_IDX_SPARE_HI, CFG_DATA_W'($urandom_range(0, 511)));
    end
    write_cfg(CFG_IDX_WIDTH, cols[CFG_DATA_W-1:0]);
    write_cfg(CFG_IDX_HEIGHT, rows[CFG_DATA_W-1:0]);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int burst_left, kind, sx, sy, ex, ey, recent_x, recent_y;
    bit have_recent;
    burst_left  = 0;
    have_recent = 1'b0;
    recent_x    = 0;
    recent_y    = 0;

    // Reset, then wait out the clearing pass
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    // Directed items at the reset geometry
    probe(0, 0);
    draw(5, 5, 5, 5);
    probe(5, 5);
    draw(0, 0, 20, 7);
    draw(20, 0, 0, 7);
    draw(3, 0, 8, 30);
    draw(10, 40, 2, 10);
    draw(0, 0, 15, 15);
    draw(0, 0, 2, 1);
    draw(0, 0, 1, 2);
    draw(0, 100, 223, 100);
    draw(50, 191, 50, 0);
    draw(-2048, -2048, 2047, 2047);
    draw(2047, -2048, -2048, 2047);
    draw(-2048, 2047, -1000, 2047);
    probe(255, 255);
    probe(223, 191);
    probe(224, 50);

    // Register extremes: zero size, above the grid size, single cell
    settle();
    program_grid(0, 0, 1'b0);
    draw(0, 0, 10, 10);
    probe(5, 5);
    settle();
    program_grid(511, 300, 1'b1);
    draw(200, 255, 255, 255);
    probe(255, 255);
    settle();
    program_grid(1, 1, 1'b1);
    draw(-3, 0, 3, 0);
    probe(0, 0);

    // Random phases, each under its own geometry
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: program_grid(256, 256, 1'b0);
        1: program_grid(GRID_W_RESET, GRID_H_RESET, 1'b0);
        2: program_grid($urandom_range(257, 511), $urandom_range(257, 511), 1'b1);
        3: program_grid($urandom_range(1, 16), $urandom_range(1, 256), 1'b1);
        4: program_grid($urandom_range(1, 256), $urandom_range(1, 256), 1'b0);
        default: program_grid($urandom_range(0, 511), $urandom_range(0, 511), 1'b1);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Idle between most bursts of back-to-back items
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk_i);
          end
        end
        burst_left--;
        if ($urandom_range(0, 9) < 4) begin
          // Read back a cell of a recent line half the time
          if (have_recent && $urandom_range(0, 1) == 1) probe(recent_x, recent_y);
          else probe($urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          kind = $urandom_range(0, 99);
          if (kind < 80) begin
            sx = $urandom_range(0, 300) - 20;
            sy = $urandom_range(0, 300) - 20;
            ex = sx + $urandom_range(0, 80) - 40;
            ey = sy + $urandom_range(0, 80) - 40;
          end else if (kind < 95) begin
            sx = $urandom_range(0, 900) - 300;
            sy = $urandom_range(0, 900) - 300;
            ex = sx + $urandom_range(0, 600) - 300;
            ey = sy + $urandom_range(0, 600) - 300;
          end else begin
            sx = $urandom_range(0, 4095) - 2048;
            sy = $urandom_range(0, 4095) - 2048;
            ex = $urandom_range(0, 4095) - 2048;
            ey = $urandom_range(0, 4095) - 2048;
          end
          draw(sx, sy, ex, ey);
          if (sx >= 0 && sx < 256 && sy >= 0 && sy < 256) begin
            recent_x    = sx;
            recent_y    = sy;
            have_recent = 1'b1;
          end
        end
      end
      start <= 1'b0;
    end

    // Drain, then leave room for a stray strobe
    settle();
    repeat (8) @(posedge clk_i);
    if (sb.pending_cell_counts.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_cell_counts.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
